// ===== hw/rtl/tfrp_pkg.sv =====
package tfrp_pkg;

    // Time base and level confirmation window.
    localparam int unsigned LEVEL_CONFIRM_MS = 500;
    localparam int unsigned UNIT_MS          = 100;

    localparam logic [31:0] LEVEL_CONFIRM_W = 32'(LEVEL_CONFIRM_MS);
    localparam logic [31:0] UNIT_MS_W       = 32'(UNIT_MS);

    // System status bit that flags an abnormal unit.
    localparam int unsigned SYS_FAULT_BIT = 7;

    localparam logic [15:0] FAIL_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_MODE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_DELAY    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RUN_TIME   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMPLETE_DELAY = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARNING_DELAY  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FAIL_COUNT = 3'd6;

    // Reset values of the delay registers, in units.
    localparam int unsigned START_DELAY_RST    = 20;
    localparam int unsigned MAX_RUN_TIME_RST   = 3000;
    localparam int unsigned COMPLETE_DELAY_RST = 50;
    localparam int unsigned WARNING_DELAY_RST  = 100;
    localparam logic [15:0] MAX_FAIL_RST       = 16'd3;

    localparam logic [31:0] START_MS_RST    = 32'(START_DELAY_RST * UNIT_MS);
    localparam logic [31:0] RUN_MS_RST      = 32'(MAX_RUN_TIME_RST * UNIT_MS);
    localparam logic [31:0] COMPLETE_MS_RST = 32'(COMPLETE_DELAY_RST * UNIT_MS);
    localparam logic [31:0] WARN2_MS_RST    = 32'(2 * WARNING_DELAY_RST * UNIT_MS);

    // Reported phase codes.
    localparam logic [2:0] PH_CODE_IDLE      = 3'd0;
    localparam logic [2:0] PH_CODE_STARTING  = 3'd1;
    localparam logic [2:0] PH_CODE_RUNNING   = 3'd2;
    localparam logic [2:0] PH_CODE_STOPPING  = 3'd3;
    localparam logic [2:0] PH_CODE_COMPLETED = 3'd4;
    localparam logic [2:0] PH_CODE_TIMEOUT   = 3'd5;
    localparam logic [2:0] PH_CODE_ERROR     = 3'd6;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_STARTING  = 7'b0000010,
        PH_RUNNING   = 7'b0000100,
        PH_STOPPING  = 7'b0001000,
        PH_COMPLETED = 7'b0010000,
        PH_TIMEOUT   = 7'b0100000,
        PH_ERROR     = 7'b1000000
    } t_phase;

    // Configuration as seen by the sequencer, delays already scaled to ms.
    typedef struct packed {
        logic        enable;
        logic        manual_mode;
        logic [31:0] start_ms;
        logic [31:0] run_ms;
        logic [31:0] complete_ms;
        logic [31:0] warn2_ms;
        logic [15:0] max_fail;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        pump_running;
        logic        tank_full;
        logic        refill_req;
        logic        leak_alarm;
        logic [15:0] unit_status;
    } t_item;

    typedef struct packed {
        logic        pump_write;
        logic        pump_run;
        logic        fail_write;
        logic [15:0] fail_tally;
        logic [2:0]  phase_code;
    } t_result;

    function automatic logic [2:0] phase_to_code(input t_phase ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:      code = PH_CODE_IDLE;
            PH_STARTING:  code = PH_CODE_STARTING;
            PH_RUNNING:   code = PH_CODE_RUNNING;
            PH_STOPPING:  code = PH_CODE_STOPPING;
            PH_COMPLETED: code = PH_CODE_COMPLETED;
            PH_TIMEOUT:   code = PH_CODE_TIMEOUT;
            PH_ERROR:     code = PH_CODE_ERROR;
            default:      code = PH_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/tfrp_if.sv =====
interface tfrp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        pump_running;
    logic        tank_full;
    logic        refill_req;
    logic        leak_alarm;
    logic [15:0] unit_status;

    modport source (
        output valid, now_ms, pump_running, tank_full, refill_req,
               leak_alarm, unit_status,
        input  ready
    );
    modport sink (
        input  valid, now_ms, pump_running, tank_full, refill_req,
               leak_alarm, unit_status,
        output ready
    );
endinterface

interface tfrp_out_if;
    logic        valid;
    logic        ready;
    logic        pump_write;
    logic        pump_run;
    logic        fail_write;
    logic [15:0] fail_tally;
    logic [2:0]  phase_code;

    modport source (
        output valid, pump_write, pump_run, fail_write, fail_tally, phase_code,
        input  ready
    );
    modport sink (
        input  valid, pump_write, pump_run, fail_write, fail_tally, phase_code,
        output ready
    );
endinterface

interface tfrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [15:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

// ===== hw/rtl/tfrp_cfg.sv =====
module tfrp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic [tfrp_pkg::CFG_ADDR_W-1:0]    i_addr,
    input  logic [15:0]                        i_data,
    output tfrp_pkg::t_cfg                     o_cfg
);
    import tfrp_pkg::*;

    t_cfg        r_cfg;
    logic [31:0] n_scaled;

    // Delays are scaled to milliseconds once, when they are written.
    assign n_scaled = 32'(i_data) * UNIT_MS_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b1;
            r_cfg.manual_mode <= 1'b0;
            r_cfg.start_ms    <= START_MS_RST;
            r_cfg.run_ms      <= RUN_MS_RST;
            r_cfg.complete_ms <= COMPLETE_MS_RST;
            r_cfg.warn2_ms    <= WARN2_MS_RST;
            r_cfg.max_fail    <= MAX_FAIL_RST;
        end else if (i_wr) begin
            unique case (i_addr)
                CFG_ENABLE:         r_cfg.enable      <= i_data[0];
                CFG_MANUAL_MODE:    r_cfg.manual_mode <= i_data[0];
                CFG_START_DELAY:    r_cfg.start_ms    <= n_scaled;
                CFG_MAX_RUN_TIME:   r_cfg.run_ms      <= n_scaled;
                CFG_COMPLETE_DELAY: r_cfg.complete_ms <= n_scaled;
                CFG_WARNING_DELAY:  r_cfg.warn2_ms    <= {n_scaled[30:0], 1'b0};
                CFG_MAX_FAIL_COUNT: r_cfg.max_fail    <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/tfrp_core.sv =====
module tfrp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  tfrp_pkg::t_item    i_item,
    input  tfrp_pkg::t_cfg     i_cfg,
    output tfrp_pkg::t_result  o_result
);
    import tfrp_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [31:0] r_phase_stamp, n_phase_stamp;
    logic [31:0] r_level_stamp, n_level_stamp;
    logic        r_level_armed, n_level_armed;
    logic [15:0] r_fail_total,  n_fail_total;

    logic        active;
    logic        sys_ok;
    logic [31:0] elapsed;
    logic        level_ok;
    logic        pw;
    logic        pr;
    logic        fw;

    assign active   = i_cfg.enable && !i_cfg.manual_mode;
    assign sys_ok   = !i_item.unit_status[SYS_FAULT_BIT];
    assign elapsed  = i_item.now_ms - r_phase_stamp;
    // Level is confirmed once armed and held for the full window.
    assign level_ok = r_level_armed && ((i_item.now_ms - r_level_stamp) >= LEVEL_CONFIRM_W);

    always_comb begin
        n_phase       = r_phase;
        n_phase_stamp = r_phase_stamp;
        n_level_stamp = r_level_stamp;
        n_level_armed = r_level_armed;
        n_fail_total  = r_fail_total;
        pw            = 1'b0;
        pr            = 1'b0;
        fw            = 1'b0;
        if (active) begin
            unique case (r_phase)
                PH_STARTING: begin
                    if (elapsed >= i_cfg.start_ms) begin
                        pw            = 1'b1;
                        pr            = 1'b1;
                        n_phase       = PH_RUNNING;
                        n_phase_stamp = i_item.now_ms;
                    end
                end
                PH_RUNNING: begin
                    if (!i_item.pump_running) begin
                        // Lost pump: no command, the run start stamp is kept.
                        n_phase = PH_ERROR;
                    end else if (i_item.tank_full) begin
                        if (!r_level_armed) begin
                            n_level_stamp = i_item.now_ms;
                            n_level_armed = 1'b1;
                        end else if (level_ok) begin
                            pw            = 1'b1;
                            n_phase       = PH_COMPLETED;
                            n_phase_stamp = i_item.now_ms;
                            n_level_armed = 1'b0;
                        end
                    end else if (i_item.leak_alarm || !sys_ok) begin
                        pw            = 1'b1;
                        n_phase       = PH_ERROR;
                        n_phase_stamp = i_item.now_ms;
                    end else begin
                        if (elapsed >= i_cfg.run_ms) begin
                            pw            = 1'b1;
                            n_phase       = PH_TIMEOUT;
                            n_phase_stamp = i_item.now_ms;
                            if (r_fail_total != FAIL_MAX) begin
                                n_fail_total = r_fail_total + 16'd1;
                                fw           = 1'b1;
                            end
                        end
                        n_level_armed = 1'b0;
                    end
                end
                PH_STOPPING: begin
                    if (!i_item.pump_running) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_COMPLETED: begin
                    if (elapsed >= i_cfg.complete_ms) begin
                        if (r_fail_total != 16'd0) begin
                            n_fail_total = 16'd0;
                            fw           = 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end
                end
                PH_TIMEOUT, PH_ERROR: begin
                    if (elapsed >= i_cfg.warn2_ms) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_item.refill_req && !i_item.tank_full) begin
                        if (!r_level_armed) begin
                            n_level_stamp = i_item.now_ms;
                            n_level_armed = 1'b1;
                        end else if (level_ok) begin
                            if (sys_ok && !i_item.leak_alarm
                                    && (r_fail_total < i_cfg.max_fail)) begin
                                n_phase_stamp = i_item.now_ms;
                                if (i_cfg.start_ms == 32'd0) begin
                                    pw      = 1'b1;
                                    pr      = 1'b1;
                                    n_phase = PH_RUNNING;
                                end else begin
                                    n_phase = PH_STARTING;
                                end
                            end
                            n_level_armed = 1'b0;
                        end
                    end else begin
                        n_level_armed = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_stamp <= 32'd0;
            r_level_stamp <= 32'd0;
            r_level_armed <= 1'b0;
            r_fail_total  <= 16'd0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_phase_stamp <= n_phase_stamp;
            r_level_stamp <= n_level_stamp;
            r_level_armed <= n_level_armed;
            r_fail_total  <= n_fail_total;
        end
    end

    assign o_result.pump_write = pw;
    assign o_result.pump_run   = pr;
    assign o_result.fail_write = fw;
    assign o_result.fail_tally = n_fail_total;
    assign o_result.phase_code = phase_to_code(n_phase);

endmodule

// ===== hw/rtl/tank_refill_pump_sequencer_top.sv =====
// Tank refill pump sequencer. Each input transaction is one control tick with
// the millisecond time and the tank sensor levels; each tick yields exactly one
// output transaction with the pump command, the failure count and the phase.
// The block takes one tick per clock cycle unless a stalled output holds off
// ticks: a tick waits in the input register, the sequencer works it out in
// combinational logic, and the result lands in the output register. The input
// register keeps accepting while a result waits, and only a stalled output with
// a full input register holds off new ticks. Configuration writes are taken in
// any cycle; delay registers are converted to milliseconds at the moment they
// are written, so a write is effective from the next tick.
module tank_refill_pump_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfrp_in_if.sink     i_in,
    tfrp_out_if.source  o_out,
    tfrp_cfg_if.sink    i_cfg
);
    import tfrp_pkg::*;

    // Input stage holding one accepted tick.
    logic    r_in_valid;
    t_item   r_in;

    // Output stage holding one finished result.
    logic    r_out_valid;
    t_result r_out;

    t_cfg    cfg;
    t_result result;
    logic    fire;
    logic    cfg_wr;

    // A tick is processed when the output stage is free or being emptied.
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    // The register file never stalls a configuration transaction.
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.now_ms       <= i_in.now_ms;
            r_in.pump_running <= i_in.pump_running;
            r_in.tank_full    <= i_in.tank_full;
            r_in.refill_req   <= i_in.refill_req;
            r_in.leak_alarm   <= i_in.leak_alarm;
            r_in.unit_status  <= i_in.unit_status;
        end
    end

    tfrp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_addr  (i_cfg.addr),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // The sequencer state advances only on the cycle a tick moves to the output.
    tfrp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pump_write = r_out.pump_write;
    assign o_out.pump_run   = r_out.pump_run;
    assign o_out.fail_write = r_out.fail_write;
    assign o_out.fail_tally = r_out.fail_tally;
    assign o_out.phase_code = r_out.phase_code;

endmodule
